// ===== src/wams_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the weighted adjacency matrix store.
// No dependencies; imported by the controller, datapath and top level.
package wams_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int VCNT_W = 5;
    localparam int VTX_W  = 6;
    localparam int WGT_W  = 16;
    localparam int NIDX_W = 5;
    // compare width: covers vertex numbers, the count register and up to 64 vertices
    localparam int CMP_W  = 7;

    localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd6;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_LIST = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WR2,
        S_DONE_OK,
        S_DONE_ERR,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        OUT_OK_DONE,
        OUT_ERR_DONE,
        OUT_PEND_MORE,
        OUT_PEND_LAST
    } t_out_kind;

    typedef struct packed {
        logic      clr_en;
        logic      load;
        logic      wr_en;
        logic      wr_swap;
        logic      scan_start;
        logic      rd_en;
        logic      consume;
        logic      out_load;
        t_out_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd;
        logic a_ok;
        logic b_ok;
        logic clr_last;
        logic col_done;
        logic rd_vld;
        logic rd_nz;
        logic pend_vld;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/wams_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: weight matrix memory, request registers, row scan, pending
// neighbor and output register. Depends on wams_pkg.
module wams_datapath import wams_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [VCNT_W-1:0] i_cfg_wr_data,
    input  logic              i_cmd,
    input  logic [VTX_W-1:0]  i_vertex_a,
    input  logic [VTX_W-1:0]  i_vertex_b,
    input  logic [WGT_W-1:0]  i_new_weight,
    input  t_dp_cmd           i_ctl,
    input  logic              i_out_ready,
    output t_dp_status        o_st,
    output logic              o_out_valid,
    output logic              o_status,
    output logic              o_neighbor_valid,
    output logic [NIDX_W-1:0] o_neighbor_index,
    output logic [WGT_W-1:0]  o_edge_weight,
    output logic              o_last
);

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AW    = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;

    logic [WGT_W-1:0] r_mem [DEPTH];

    logic [VCNT_W-1:0] r_vcount;
    logic              r_cmd;
    logic [VTX_W-1:0]  r_a;
    logic [VTX_W-1:0]  r_b;
    logic [WGT_W-1:0]  r_w;
    logic [AW-1:0]     r_clr_addr;
    logic [IDX_W:0]    r_col;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_col;
    logic [WGT_W-1:0]  r_rd_data;
    logic              r_pend_vld;
    logic [NIDX_W-1:0] r_pend_idx;
    logic [WGT_W-1:0]  r_pend_w;
    logic              r_out_vld;
    logic              r_out_status;
    logic              r_out_nvld;
    logic [NIDX_W-1:0] r_out_idx;
    logic [WGT_W-1:0]  r_out_w;
    logic              r_out_last;

    logic [CMP_W-1:0]  w_eff;
    logic [VTX_W-1:0]  w_a_m1;
    logic [VTX_W-1:0]  w_b_m1;
    logic [IDX_W-1:0]  w_ra;
    logic [IDX_W-1:0]  w_rb;
    logic [AW-1:0]     w_wr_addr;
    logic [WGT_W-1:0]  w_wr_data;
    logic              w_wr_en;
    logic [AW-1:0]     w_rd_addr;
    logic [CMP_W-1:0]  w_next_idx;
    logic              n_rd_vld;

    assign w_eff = (CMP_W'(r_vcount) > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES)
                                                             : CMP_W'(r_vcount);
    assign w_a_m1 = r_a - VTX_W'(1);
    assign w_b_m1 = r_b - VTX_W'(1);
    assign w_ra   = w_a_m1[IDX_W-1:0];
    assign w_rb   = w_b_m1[IDX_W-1:0];

    always_comb begin
        w_wr_en   = i_ctl.clr_en | i_ctl.wr_en;
        w_wr_data = i_ctl.clr_en ? '0 : r_w;
        if (i_ctl.clr_en) begin
            w_wr_addr = r_clr_addr;
        end else if (i_ctl.wr_swap) begin
            w_wr_addr = {w_rb, w_ra};
        end else begin
            w_wr_addr = {w_ra, w_rb};
        end
    end

    assign w_rd_addr  = {w_ra, r_col[IDX_W-1:0]};
    assign w_next_idx = CMP_W'(r_rd_col) + CMP_W'(1);

    always_comb begin
        if (i_ctl.scan_start) begin
            n_rd_vld = 1'b0;
        end else if (i_ctl.rd_en) begin
            n_rd_vld = 1'b1;
        end else if (i_ctl.consume) begin
            n_rd_vld = 1'b0;
        end else begin
            n_rd_vld = r_rd_vld;
        end
    end

    // matrix memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_col  <= r_col[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount   <= VCNT_RESET;
            r_clr_addr <= '0;
            r_col      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            if (i_ctl.clr_en) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_ctl.scan_start) begin
                r_col <= '0;
            end else if (i_ctl.rd_en) begin
                r_col <= r_col + (IDX_W+1)'(1);
            end
            r_rd_vld <= n_rd_vld;
            if (i_ctl.scan_start) begin
                r_pend_vld <= 1'b0;
            end else if (i_ctl.consume && (r_rd_data != '0)) begin
                r_pend_vld <= 1'b1;
            end
            if (i_ctl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_a   <= i_vertex_a;
            r_b   <= i_vertex_b;
            r_w   <= i_new_weight;
        end
        if (i_ctl.consume && (r_rd_data != '0)) begin
            r_pend_idx <= w_next_idx[NIDX_W-1:0];
            r_pend_w   <= r_rd_data;
        end
        if (i_ctl.out_load) begin
            case (i_ctl.out_kind)
                OUT_ERR_DONE: begin
                    r_out_status <= 1'b1;
                    r_out_nvld   <= 1'b0;
                    r_out_idx    <= '0;
                    r_out_w      <= '0;
                    r_out_last   <= 1'b1;
                end
                OUT_PEND_MORE: begin
                    r_out_status <= 1'b0;
                    r_out_nvld   <= 1'b1;
                    r_out_idx    <= r_pend_idx;
                    r_out_w      <= r_pend_w;
                    r_out_last   <= 1'b0;
                end
                OUT_PEND_LAST: begin
                    r_out_status <= 1'b0;
                    r_out_nvld   <= 1'b1;
                    r_out_idx    <= r_pend_idx;
                    r_out_w      <= r_pend_w;
                    r_out_last   <= 1'b1;
                end
                default: begin
                    r_out_status <= 1'b0;
                    r_out_nvld   <= 1'b0;
                    r_out_idx    <= '0;
                    r_out_w      <= '0;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_st.cmd      = r_cmd;
        o_st.a_ok     = (r_a != '0) && (CMP_W'(r_a) <= w_eff);
        o_st.b_ok     = (r_b != '0) && (CMP_W'(r_b) <= w_eff);
        o_st.clr_last = (r_clr_addr == AW'(DEPTH - 1));
        o_st.col_done = (CMP_W'(r_col) >= w_eff);
        o_st.rd_vld   = r_rd_vld;
        o_st.rd_nz    = (r_rd_data != '0);
        o_st.pend_vld = r_pend_vld;
        o_st.out_free = !r_out_vld || i_out_ready;
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out_status;
    assign o_neighbor_valid = r_out_nvld;
    assign o_neighbor_index = r_out_idx;
    assign o_edge_weight    = r_out_w;
    assign o_last           = r_out_last;

endmodule

// ===== src/wams_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: clearing pass, request decode, edge writes,
// row scan sequencing and result hand-off. Depends on wams_pkg.
module wams_ctrl import wams_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   w_stall;

    assign w_stall = i_st.rd_vld && i_st.rd_nz && i_st.pend_vld && !i_st.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_en = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.cmd == CMD_SET) begin
                    if (i_st.a_ok && i_st.b_ok) begin
                        o_ctl.wr_en = 1'b1;
                        n_state     = S_WR2;
                    end else begin
                        n_state = S_DONE_ERR;
                    end
                end else if (i_st.a_ok) begin
                    o_ctl.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_DONE_ERR;
                end
            end
            S_WR2: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_swap = 1'b1;
                n_state       = S_DONE_OK;
            end
            S_DONE_OK: begin
                if (i_st.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = OUT_OK_DONE;
                    n_state        = S_IDLE;
                end
            end
            S_DONE_ERR: begin
                if (i_st.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = OUT_ERR_DONE;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!w_stall) begin
                    o_ctl.consume  = i_st.rd_vld;
                    o_ctl.out_load = i_st.rd_vld && i_st.rd_nz && i_st.pend_vld;
                    o_ctl.out_kind = OUT_PEND_MORE;
                    o_ctl.rd_en    = !i_st.col_done;
                end
                if (i_st.col_done && !i_st.rd_vld) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_st.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = i_st.pend_vld ? OUT_PEND_LAST : OUT_OK_DONE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.rd_en |-> !i_st.col_done)
        else $error("row read issued past the vertex count");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> i_st.out_free)
        else $error("result loaded over an untaken result");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_no_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.wr_en || o_ctl.clr_en) |-> !(o_ctl.rd_en || o_ctl.consume))
        else $error("matrix write during row scan");

endmodule

// ===== src/weighted_adjacency_matrix_store_core.sv =====
`timescale 1ns / 1ps
// Top level of the weighted adjacency matrix store: streaming ports around
// the controller and datapath. Depends on wams_pkg, wams_ctrl, wams_datapath.
//
// Usage:
//   Requests enter on s_axis: tuser[0] selects set (0) or list (1), tdata
//   carries vertex_a, vertex_b and new_weight. Results leave on m_axis:
//   tuser carries status and neighbor_valid, tdata the neighbor number and
//   edge weight, tlast marks the final result of a request.
//   Vertex count is written through i_cfg_wr_en / i_cfg_wr_data while idle.
//   One request at a time; a set runs decode with first write, second
//   write, then result, an out-of-range vertex decode, then result, and a
//   list scans the first n row entries, n the effective vertex count: the
//   row is read one entry per cycle, unless a stall on m_axis holds it,
//   from the single read port, and each neighbor is held back one step so
//   the last one can be marked. After reset the matrix is cleared one entry
//   per cycle, all 256 entries at 16 vertices; s_axis_tready stays low
//   meanwhile, vertex count returns to 6.
//   A result sits in the output register until taken; a stall on m_axis
//   holds the scan, and the next request is taken once the last result
//   of the current one is registered.
module weighted_adjacency_matrix_store_core import wams_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [VCNT_W-1:0] i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // vertex_a[5:0], vertex_b[11:6], new_weight[27:12]
    input  logic [0:0]        s_axis_tuser,  // command[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // neighbor_index[4:0], edge_weight[20:5]
    output logic [1:0]        m_axis_tuser,  // status[0], neighbor_valid[1]
    output logic              m_axis_tlast
);

    t_dp_cmd           w_ctl;
    t_dp_status        w_st;
    logic              w_status;
    logic              w_nvld;
    logic [NIDX_W-1:0] w_nidx;
    logic [WGT_W-1:0]  w_ew;

    wams_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (w_st),
        .o_ctl      (w_ctl)
    );

    wams_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (s_axis_tuser[0]),
        .i_vertex_a       (s_axis_tdata[5:0]),
        .i_vertex_b       (s_axis_tdata[11:6]),
        .i_new_weight     (s_axis_tdata[27:12]),
        .i_ctl            (w_ctl),
        .i_out_ready      (m_axis_tready),
        .o_st             (w_st),
        .o_out_valid      (m_axis_tvalid),
        .o_status         (w_status),
        .o_neighbor_valid (w_nvld),
        .o_neighbor_index (w_nidx),
        .o_edge_weight    (w_ew),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_ew, w_nidx};
    assign m_axis_tuser = {w_nvld, w_status};

endmodule

// ===== bench/adjacency_matrix_checker.sv =====
`timescale 1ns / 1ps
// Checker for the weighted adjacency matrix store: watches the request, result and
// config channels, keeps its own copy of the matrix and compares every result.
// Depends on wams_pkg.
module adjacency_matrix_checker import wams_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [VCNT_W-1:0] i_cfg_wr_data,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [31:0]       i_req_data,   // vertex_a[5:0], vertex_b[11:6], new_weight[27:12]
    input  logic [0:0]        i_req_user,   // command[0]
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [23:0]       i_res_data,   // neighbor_index[4:0], edge_weight[20:5]
    input  logic [1:0]        i_res_user,   // status[0], neighbor_valid[1]
    input  logic              i_res_last,
    output int                o_error_count,
    output int                o_pending
);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic              status;
        logic              nbr_valid;
        logic [NIDX_W-1:0] nbr_index;
        logic [WGT_W-1:0]  weight;
        logic              last;
    } t_edge_result;

    logic [WGT_W-1:0]  edge_weights [DEF_MAX_VERTICES][DEF_MAX_VERTICES];
    logic [VCNT_W-1:0] vertex_count;
    t_edge_result      expected_results [$];
    int                errors = 0;

    function automatic int active_vertices();
        return (int'(vertex_count) > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(vertex_count);
    endfunction

    function automatic bit vertex_in_range(logic [VTX_W-1:0] v);
        return (int'(v) >= 1) && (int'(v) <= active_vertices());
    endfunction

    function automatic t_edge_result closing_result(logic status);
        t_edge_result r;
        r = '0;
        r.status = status;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic apply_request(logic cmd, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                                 logic [WGT_W-1:0] w);
        t_edge_result held;
        bit           have_held;
        int           ra;
        int           rb;
        ra = int'(va) - 1;
        rb = int'(vb) - 1;
        have_held = 1'b0;
        held = '0;
        if (cmd == CMD_SET) begin
            if (!vertex_in_range(va) || !vertex_in_range(vb)) begin
                expected_results.push_back(closing_result(STATUS_RANGE));
            end else begin
                edge_weights[ra][rb] = w;
                edge_weights[rb][ra] = w;
                expected_results.push_back(closing_result(STATUS_OK));
            end
        end else if (!vertex_in_range(va)) begin
            expected_results.push_back(closing_result(STATUS_RANGE));
        end else begin
            // hold each neighbor back one step so the final one can carry last
            for (int i = 0; i < active_vertices(); i++) begin
                if (edge_weights[ra][i] != '0) begin
                    if (have_held) begin
                        expected_results.push_back(held);
                    end
                    held.status    = STATUS_OK;
                    held.nbr_valid = 1'b1;
                    held.nbr_index = NIDX_W'(i + 1);
                    held.weight    = edge_weights[ra][i];
                    held.last      = 1'b0;
                    have_held      = 1'b1;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_results.push_back(held);
            end else begin
                expected_results.push_back(closing_result(STATUS_OK));
            end
        end
    endtask

    task automatic check_result(t_edge_result got);
        t_edge_result want;
        if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: unexpected result status=%0b valid=%0b index=%0d %s",
                         $realtime, got.status, got.nbr_valid, got.nbr_index,
                         $sformatf("weight=%h last=%0b", got.weight, got.last));
            end
        end else begin
            want = expected_results.pop_front();
            if (want.status !== got.status || want.nbr_valid !== got.nbr_valid ||
                want.nbr_index !== got.nbr_index || want.weight !== got.weight ||
                want.last !== got.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch expected status=%0b valid=%0b index=%0d %s",
                             $realtime, want.status, want.nbr_valid, want.nbr_index,
                             $sformatf("weight=%h last=%0b", want.weight, want.last));
                    $display("%0t:            actual status=%0b valid=%0b index=%0d %s",
                             $realtime, got.status, got.nbr_valid, got.nbr_index,
                             $sformatf("weight=%h last=%0b", got.weight, got.last));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_count = VCNT_RESET;
            for (int r = 0; r < DEF_MAX_VERTICES; r++) begin
                for (int c = 0; c < DEF_MAX_VERTICES; c++) begin
                    edge_weights[r][c] = '0;
                end
            end
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                vertex_count = i_cfg_wr_data;
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_user[0], i_req_data[5:0], i_req_data[11:6],
                              i_req_data[27:12]);
            end
            if (i_res_valid && i_res_ready) begin
                check_result({i_res_user[0], i_res_user[1], i_res_data[4:0],
                              i_res_data[20:5], i_res_last});
            end
        end
        o_pending     <= expected_results.size();
        o_error_count <= errors;
    end

endmodule

// ===== bench/weighted_adjacency_matrix_store_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for weighted_adjacency_matrix_store_core: drives requests, config
// writes and result back-pressure; checking is done in adjacency_matrix_checker.
// Depends on wams_pkg, the core and adjacency_matrix_checker.
module weighted_adjacency_matrix_store_core_tb;
    import wams_pkg::*;

    localparam int CLK_HALF = 6;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_ALTERNATE
    } t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [VCNT_W-1:0] i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;  // vertex_a[5:0], vertex_b[11:6], new_weight[27:12]
    logic [0:0]        s_axis_tuser = '0;  // command[0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;       // neighbor_index[4:0], edge_weight[20:5]
    logic [1:0]        m_axis_tuser;       // status[0], neighbor_valid[1]
    logic              m_axis_tlast;

    int error_count;
    int pending_results;
    int active_count = 6;
    int burst_left = 0;
    bit rx_hold_request = 1'b0;

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    weighted_adjacency_matrix_store_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    adjacency_matrix_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .i_res_last    (m_axis_tlast),
        .o_error_count (error_count),
        .o_pending     (pending_results)
    );

    // sender works in bursts; a new burst may start after an idle gap
    task automatic send_request(logic cmd, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                                logic [WGT_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, w, vb, va};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_request();
        logic             cmd;
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic [WGT_W-1:0] w;
        w = WGT_W'($urandom);
        if ($urandom_range(0, 99) < 10 || active_count == 0) begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_SET : CMD_LIST;
            va  = VTX_W'($urandom);
            vb  = VTX_W'($urandom);
        end else begin
            cmd = ($urandom_range(0, 99) < 55) ? CMD_SET : CMD_LIST;
            va  = VTX_W'($urandom_range(1, active_count));
            vb  = VTX_W'($urandom_range(1, active_count));
            case ($urandom_range(0, 9))
                0, 1:    w = '0;
                2:       w = 16'h7FFF;
                3:       w = 16'h8000;
                default: ;
            endcase
        end
        send_request(cmd, va, vb, w);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results != 0 || !s_axis_tready);
    endtask

    task automatic write_vertex_count(logic [VCNT_W-1:0] value);
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_count = (int'(value) > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(value);
    endtask

    // result side: stall patterns in segments, plus one long hold-off on request
    initial begin
        t_rx_mode mode;
        int       seg;
        forever begin
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                seg  = $urandom_range(4, 40);
                mode = t_rx_mode'($urandom_range(0, 3));
                repeat (seg) begin
                    case (mode)
                        RX_ALWAYS:    m_axis_tready <= 1'b1;
                        RX_MOSTLY:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                        RX_SPARSE:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                        RX_ALTERNATE: m_axis_tready <= ~m_axis_tready;
                        default:      m_axis_tready <= 1'b1;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #(2 * CLK_HALF * 400000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_results_drained();

        // reset vertex count of six
        send_request(CMD_LIST, 6'd1, 6'd0, 16'h0000);
        send_request(CMD_SET, 6'd1, 6'd2, 16'h7FFF);
        send_request(CMD_SET, 6'd2, 6'd6, 16'h8000);
        send_request(CMD_SET, 6'd3, 6'd3, 16'h0001);
        send_request(CMD_SET, 6'd0, 6'd2, 16'h0005);
        send_request(CMD_SET, 6'd2, 6'd7, 16'h0005);
        send_request(CMD_SET, 6'd63, 6'd63, 16'hFFFF);
        send_request(CMD_LIST, 6'd0, 6'd0, 16'h0000);
        send_request(CMD_LIST, 6'd7, 6'd63, 16'hFFFF);
        send_request(CMD_LIST, 6'd2, 6'd0, 16'h0000);
        send_request(CMD_LIST, 6'd3, 6'd0, 16'h0000);
        send_request(CMD_SET, 6'd6, 6'd1, 16'hFFFF);
        send_request(CMD_LIST, 6'd6, 6'd0, 16'h0000);
        send_request(CMD_SET, 6'd2, 6'd1, 16'h0000);
        send_request(CMD_LIST, 6'd1, 6'd0, 16'h0000);
        send_request(CMD_LIST, 6'd2, 6'd0, 16'h0000);
        send_request(CMD_SET, 6'd6, 6'd6, 16'h0000);
        send_request(CMD_LIST, 6'd4, 6'd0, 16'h0000);

        // zero count: every vertex out of range
        write_vertex_count(5'd0);
        send_request(CMD_SET, 6'd1, 6'd1, 16'h0001);
        send_request(CMD_LIST, 6'd1, 6'd0, 16'h0000);

        // count above the array acts as the array size
        write_vertex_count(5'd31);
        send_request(CMD_SET, 6'd16, 6'd1, 16'h1234);
        send_request(CMD_SET, 6'd17, 6'd1, 16'h1234);
        send_request(CMD_LIST, 6'd17, 6'd0, 16'h0000);
        send_request(CMD_LIST, 6'd16, 6'd0, 16'h0000);

        // single vertex
        write_vertex_count(5'd1);
        send_request(CMD_SET, 6'd1, 6'd1, 16'hFFFB);
        send_request(CMD_SET, 6'd1, 6'd2, 16'h0003);
        send_request(CMD_LIST, 6'd1, 6'd0, 16'h0000);
        send_request(CMD_LIST, 6'd2, 6'd0, 16'h0000);

        // full array: one complete row, then random traffic
        write_vertex_count(5'd16);
        for (int k = 1; k <= DEF_MAX_VERTICES; k++) begin
            send_request(CMD_SET, 6'd16, VTX_W'(k), WGT_W'($urandom_range(1, 65535)));
        end
        send_request(CMD_LIST, 6'd16, 6'd0, 16'h0000);
        for (int i = 0; i < 45; i++) begin
            if (i == 10) begin
                rx_hold_request = 1'b1;
            end
            if (i == 30) begin
                wait_results_drained();
            end
            send_random_request();
        end

        write_vertex_count(VCNT_W'($urandom_range(2, 15)));
        repeat (10) send_random_request();

        write_vertex_count(5'd20);
        repeat (10) send_random_request();

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/wams_pkg.sv
src/wams_datapath.sv
src/wams_ctrl.sv
src/weighted_adjacency_matrix_store_core.sv
bench/adjacency_matrix_checker.sv
bench/weighted_adjacency_matrix_store_core_tb.sv
